// ===== rtl/snes_pkg.sv =====
package snes_pkg;

    localparam int MAX_EDGES = 32;
    localparam int IDX_W     = 5;
    localparam int CNT_W     = 6;
    localparam int ADDR_W    = 4;

    typedef logic signed [15:0] t_q14;
    typedef logic signed [31:0] t_q28;

    localparam logic signed [33:0] ONE_Q28 = 34'sd268435456;
    localparam logic signed [33:0] TWO_Q28 = 34'sd536870912;

    typedef enum logic [1:0] {
        REG_DIR_X = 2'd0,
        REG_DIR_Y = 2'd1,
        REG_DIR_Z = 2'd2
    } t_reg_idx;

    // ranking as it stands after the current edge
    typedef struct packed {
        logic signed [31:0] best_cos;
        logic signed [31:0] second_cos;
        logic [IDX_W-1:0]   best_idx;
        logic [IDX_W-1:0]   second_idx;
        logic               multi;
        logic               no_fwd;
    } t_snap;

    function automatic t_q28 sat32(input logic signed [32:0] v);
        if (v[32] != v[31]) begin
            return v[32] ? 32'sh80000000 : 32'sh7fffffff;
        end
        return t_q28'(v[31:0]);
    endfunction

endpackage

// ===== rtl/stochastic_next_edge_select.sv =====
// stochastic next-edge selector
// input channel (i_in_valid / o_in_ready): one beat per edge of a node, carrying
// the edge unit direction in q1.14 and a last flag; the random fraction is used
// only on the last beat of a node
// output channel (o_out_valid / i_out_ready): one beat per node, sent for the
// last edge, with the chosen edge position, a no-forward-edge flag and a flag
// telling whether the second-best edge was picked
// the travel direction sits in three apb registers (x at 0x0, y at 0x4, z at 0x8)
// throughput: one edge beat per cycle, sustained while the receiver does not stall the result register
// a last-edge beat reaches the output through a seven-register pipeline:
// input, products, saturated sum, ranking snapshot, numerator and denominator,
// cross products, result
// the ranking registers see one edge per cycle, so the compare against the best
// and second-best dot product is the loop that fixes the one-beat-per-cycle rate
// reset clears the pipeline, the ranking state and the direction (0, 0, 1.0)
// a stalled receiver holds the result register; the stages behind it keep
// filling, and o_in_ready drops only once every stage holds a beat
module stochastic_next_edge_select
    import snes_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic signed [15:0] i_edge_x,
    input  logic signed [15:0] i_edge_y,
    input  logic signed [15:0] i_edge_z,
    input  logic              i_last_edge,
    input  logic [15:0]       i_random_fraction,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [IDX_W-1:0]  o_chosen_index,
    output logic              o_no_forward_edge,
    output logic              o_took_second
);

    t_q14 r_dir_x, r_dir_y, r_dir_z;
    t_reg_idx reg_idx;
    logic     cfg_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_x <= '0;
            r_dir_y <= '0;
            r_dir_z <= 16'sd16384;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_DIR_X: r_dir_x <= t_q14'(pwdata[15:0]);
                REG_DIR_Y: r_dir_y <= t_q14'(pwdata[15:0]);
                REG_DIR_Z: r_dir_z <= t_q14'(pwdata[15:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DIR_X: prdata = {16'b0, r_dir_x};
            REG_DIR_Y: prdata = {16'b0, r_dir_y};
            REG_DIR_Z: prdata = {16'b0, r_dir_z};
            default:   prdata = '0;
        endcase
    end

    // pipeline registers
    logic        r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    logic        r_s5_valid, r_s6_valid, r_s7_valid;
    t_q14        r_s1_x, r_s1_y, r_s1_z;
    logic        r_s1_last, r_s2_last, r_s3_last;
    logic [15:0] r_s1_u, r_s2_u, r_s3_u, r_s4_u, r_s5_u;
    t_q28        r_s2_p0, r_s2_p1, r_s2_p2;
    t_q28        r_s3_cos;
    t_snap       r_s4_snap;
    logic signed [33:0] r_s5_num, r_s5_den;
    logic [IDX_W-1:0]   r_s5_best_idx, r_s5_second_idx;
    logic [IDX_W-1:0]   r_s6_best_idx, r_s6_second_idx;
    logic               r_s5_multi, r_s5_no_fwd, r_s6_multi, r_s6_no_fwd;
    logic signed [50:0] r_s6_lhs, r_s6_rhs;
    logic               r_s6_den_pos, r_s6_den_neg;
    logic [IDX_W-1:0]   r_s7_idx;
    logic               r_s7_no_fwd, r_s7_second;

    logic  rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;
    logic  fire3;
    t_snap snap;
    logic  take_second;

    assign rdy7  = !r_s7_valid || i_out_ready;
    assign rdy6  = !r_s6_valid || rdy7;
    assign rdy5  = !r_s5_valid || rdy6;
    assign rdy4  = !r_s4_valid || rdy5;
    assign rdy3  = !r_s3_valid || !r_s3_last || rdy4;
    assign rdy2  = !r_s2_valid || rdy3;
    assign rdy1  = !r_s1_valid || rdy2;
    assign fire3 = r_s3_valid && rdy3;

    assign o_in_ready = rdy1;

    snes_rank u_rank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire3),
        .i_last  (r_s3_last),
        .i_cos   (r_s3_cos),
        .o_snap  (snap)
    );

    assign take_second = r_s6_multi &&
        ((r_s6_den_pos && (r_s6_lhs < r_s6_rhs)) ||
         (r_s6_den_neg && (r_s6_lhs > r_s6_rhs)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
            r_s6_valid <= 1'b0;
            r_s7_valid <= 1'b0;
        end else begin
            if (rdy1) r_s1_valid <= i_in_valid;
            if (rdy2) r_s2_valid <= r_s1_valid;
            if (rdy3) r_s3_valid <= r_s2_valid;
            if (rdy4) r_s4_valid <= r_s3_valid && r_s3_last;
            if (rdy5) r_s5_valid <= r_s4_valid;
            if (rdy6) r_s6_valid <= r_s5_valid;
            if (rdy7) r_s7_valid <= r_s6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_x    <= i_edge_x;
            r_s1_y    <= i_edge_y;
            r_s1_z    <= i_edge_z;
            r_s1_last <= i_last_edge;
            r_s1_u    <= i_random_fraction;
        end
        if (rdy2) begin
            r_s2_p0   <= r_s1_x * r_dir_x;
            r_s2_p1   <= r_s1_y * r_dir_y;
            r_s2_p2   <= r_s1_z * r_dir_z;
            r_s2_last <= r_s1_last;
            r_s2_u    <= r_s1_u;
        end
        if (rdy3) begin
            r_s3_cos  <= sat32(33'(r_s2_p0) + 33'(r_s2_p1) + 33'(r_s2_p2));
            r_s3_last <= r_s2_last;
            r_s3_u    <= r_s2_u;
        end
        if (rdy4) begin
            r_s4_snap <= snap;
            r_s4_u    <= r_s3_u;
        end
        if (rdy5) begin
            r_s5_num        <= 34'(r_s4_snap.second_cos) + ONE_Q28;
            r_s5_den        <= 34'(r_s4_snap.second_cos) + 34'(r_s4_snap.best_cos)
                               + TWO_Q28;
            r_s5_best_idx   <= r_s4_snap.best_idx;
            r_s5_second_idx <= r_s4_snap.second_idx;
            r_s5_multi      <= r_s4_snap.multi;
            r_s5_no_fwd     <= r_s4_snap.no_fwd;
            r_s5_u          <= r_s4_u;
        end
        if (rdy6) begin
            r_s6_lhs        <= $signed({1'b0, r_s5_u}) * r_s5_den;
            r_s6_rhs        <= {r_s5_num[33], r_s5_num, 16'b0};
            r_s6_den_pos    <= !r_s5_den[33] && (r_s5_den != '0);
            r_s6_den_neg    <= r_s5_den[33];
            r_s6_best_idx   <= r_s5_best_idx;
            r_s6_second_idx <= r_s5_second_idx;
            r_s6_multi      <= r_s5_multi;
            r_s6_no_fwd     <= r_s5_no_fwd;
        end
        if (rdy7) begin
            r_s7_idx    <= take_second ? r_s6_second_idx : r_s6_best_idx;
            r_s7_no_fwd <= r_s6_no_fwd;
            r_s7_second <= take_second;
        end
    end

    assign o_out_valid       = r_s7_valid;
    assign o_chosen_index    = r_s7_idx;
    assign o_no_forward_edge = r_s7_no_fwd;
    assign o_took_second     = r_s7_second;

endmodule

// ===== rtl/snes_rank.sv =====
module snes_rank
    import snes_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_fire,
    input  logic i_last,
    input  t_q28 i_cos,
    output t_snap o_snap
);

    t_q28             r_best_cos,   n_best_cos;
    t_q28             r_second_cos, n_second_cos;
    logic [IDX_W-1:0] r_best_idx,   n_best_idx;
    logic [IDX_W-1:0] r_second_idx, n_second_idx;
    logic [CNT_W-1:0] r_edge_count, n_edge_count;
    logic [CNT_W-1:0] r_pos_count,  n_pos_count;
    logic [IDX_W-1:0] pos;
    logic             in_range;

    assign pos      = r_edge_count[IDX_W-1:0];
    assign in_range = {1'b0, r_edge_count} < (CNT_W+1)'(MAX_EDGES);

    always_comb begin
        n_best_cos   = r_best_cos;
        n_second_cos = r_second_cos;
        n_best_idx   = r_best_idx;
        n_second_idx = r_second_idx;
        n_edge_count = r_edge_count;
        n_pos_count  = r_pos_count;
        if (in_range) begin
            if (i_cos > 0 && r_pos_count != {CNT_W{1'b1}}) begin
                n_pos_count = r_pos_count + 1'b1;
            end
            if (r_edge_count == '0) begin
                n_best_cos = i_cos;
                n_best_idx = pos;
            end else if (i_cos > r_best_cos) begin
                n_second_cos = r_best_cos;
                n_second_idx = r_best_idx;
                n_best_cos   = i_cos;
                n_best_idx   = pos;
            end else if (r_edge_count == CNT_W'(1) || i_cos > r_second_cos) begin
                n_second_cos = i_cos;
                n_second_idx = pos;
            end
            n_edge_count = r_edge_count + 1'b1;
        end
    end

    always_comb begin
        o_snap.best_cos   = n_best_cos;
        o_snap.second_cos = n_second_cos;
        o_snap.best_idx   = n_best_idx;
        o_snap.second_idx = n_second_idx;
        o_snap.multi      = n_edge_count >= CNT_W'(2);
        o_snap.no_fwd     = n_pos_count == '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_last)) begin
            r_best_cos   <= '0;
            r_second_cos <= '0;
            r_best_idx   <= '0;
            r_second_idx <= '0;
            r_edge_count <= '0;
            r_pos_count  <= '0;
        end else if (i_fire) begin
            r_best_cos   <= n_best_cos;
            r_second_cos <= n_second_cos;
            r_best_idx   <= n_best_idx;
            r_second_idx <= n_second_idx;
            r_edge_count <= n_edge_count;
            r_pos_count  <= n_pos_count;
        end
    end

endmodule

// ===== rtl/snes_checker.sv =====
module snes_checker
    import snes_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_in_ready,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic [IDX_W-1:0] o_chosen_index,
    input logic             o_no_forward_edge,
    input logic             o_took_second
);

    // pipeline empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat present right after reset");

    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("input not ready right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_chosen_index) && $stable(o_no_forward_edge) && $stable(o_took_second))
        else $error("result payload changed while stalled");

endmodule

bind stochastic_next_edge_select snes_checker u_snes_checker (.*);
